>>> hw/rtl/per_key_rate_limit_table_core_defines.svh
// Assertion helpers for the checker file of this block.
`ifndef PER_KEY_RATE_LIMIT_TABLE_CORE_DEFINES_SVH
`define PER_KEY_RATE_LIMIT_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and off while reset is asserted.
`define PKRL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and off while reset is asserted.
`define PKRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pkrl_pkg.sv
package pkrl_pkg;

  // Field widths of one beat.
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned AMOUNT_W = 32;
  localparam int unsigned QUOTA_W  = 32;

  // Configuration port.
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic [0:0]  REG_QUOTA = 1'b0;

  // Opcodes.
  localparam logic OPC_TOUCH = 1'b0;
  localparam logic OPC_CHECK = 1'b1;

  // Rate arithmetic: amount * 1e6 fits in 52 bits, so dt is split in two
  // 26-bit slices for the quota product and anything above bit 51 is "large".
  localparam logic [31:0] US_PER_SEC = 32'd1000000;
  localparam int unsigned LHS_W   = 52;
  localparam int unsigned SLICE_W = 26;
  localparam int unsigned PART_W  = QUOTA_W + SLICE_W;
  localparam int unsigned SUM_W   = PART_W + SLICE_W;
  localparam int unsigned MUL_W   = 64;

  // One table entry as stored in the RAM.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
  } entry_t;

endpackage

>>> hw/rtl/pkrl_ram.sv
module pkrl_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/per_key_rate_limit_table_core.sv
// Channel  Direction  Handshake             Beat contents
// in       input      in_valid / in_stall   opcode, key_hash, now_us, amount
// out      output     out_valid / out_stall hit, stamp, over_quota
// cfg      input      APB write / read      quota_per_second at byte address 0
//
// A touch scans up to the key's slot, or every slot on a miss, then writes the entry.
// A check scans the same way and then, on a hit, runs the multiply steps; the table scan goes
// through the single RAM read port (one slot a cycle) and the 32x32 multiplier is shared.
// Reset (rst_n low, synchronous) empties the table through per-slot valid bits.
// The input stalls while a beat is in work; a result waiting on out_stall holds
// the block in its final step only until the output register frees up.
module per_key_rate_limit_table_core import pkrl_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_opcode,
  input  logic [KEY_W-1:0]    in_key_hash,
  input  logic [TIME_W-1:0]   in_now_us,
  input  logic [AMOUNT_W-1:0] in_amount,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic [TIME_W-1:0]   out_stamp,
  output logic                out_over_quota,
  // Configuration port
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CFG_AW-1:0]   cfg_paddr,
  input  logic [CFG_DW-1:0]   cfg_pwdata,
  output logic [CFG_DW-1:0]   cfg_prdata,
  output logic                cfg_pready
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SCAN = 4'd1;
  localparam logic [3:0] ST_ACT  = 4'd2;
  localparam logic [3:0] ST_MUL0 = 4'd3;
  localparam logic [3:0] ST_MUL1 = 4'd4;
  localparam logic [3:0] ST_MUL2 = 4'd5;
  localparam logic [3:0] ST_SUM  = 4'd6;
  localparam logic [3:0] ST_CMP  = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  // Control state.
  logic [3:0]         state_r, state_nxt;
  logic               issue_r, issue_nxt;
  logic               cmp_on_r, cmp_on_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [ENTRIES-1:0] vld_r, vld_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [QUOTA_W-1:0] quota_r, quota_nxt;

  // Working payload.
  logic                op_r, op_nxt;
  logic [KEY_W-1:0]    hash_r, hash_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [AMOUNT_W-1:0] amount_r, amount_nxt;
  logic [IDX_W-1:0]    addr_r, addr_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic                cmp_live_r, cmp_live_nxt;
  logic [IDX_W-1:0]    slot_r, slot_nxt;
  logic                hit_r, hit_nxt;
  logic [TIME_W-1:0]   stamp_r, stamp_nxt;
  logic                over_r, over_nxt;
  logic [TIME_W-1:0]   dt_r, dt_nxt;
  logic [MUL_W-1:0]    prod_r, prod_nxt;
  logic [LHS_W-1:0]    lhs_r, lhs_nxt;
  logic [PART_W-1:0]   acc_r, acc_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic [TIME_W-1:0]   out_stamp_r, out_stamp_nxt;
  logic                out_over_r, out_over_nxt;

  // RAM and multiplier signals.
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  entry_t           ram_wr_data;
  logic             ram_rd_en;
  entry_t           ram_rd_data;
  logic [KEY_W-1:0] cmp_key;
  logic [TIME_W-1:0] cmp_time;
  logic [IDX_W-1:0] ptr_inc;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [MUL_W-1:0] mul_p;
  logic             in_acc;
  logic             out_free;
  logic             cfg_wr;
  logic             dt_large;

  pkrl_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(addr_r),
    .rd_data(ram_rd_data)
  );

  // Handshakes and configuration access.
  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2:2] == REG_QUOTA);
  assign cfg_prdata = (cfg_paddr[2:2] == REG_QUOTA) ? quota_r : '0;

  // A slot that was never written reads as an empty entry with time zero.
  assign cmp_key  = cmp_live_r ? ram_rd_data.key : '0;
  assign cmp_time = cmp_live_r ? ram_rd_data.stamp : '0;
  assign ptr_inc  = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
  assign dt_large = |dt_r[TIME_W-1:LHS_W];

  // Table writes happen only in the action step of a touch.
  assign ram_wr_en       = (state_r == ST_ACT) && (op_r == OPC_TOUCH);
  assign ram_wr_addr     = hit_r ? slot_r : ptr_inc;
  assign ram_wr_data.key   = hash_r;
  assign ram_wr_data.stamp = now_r;
  assign ram_rd_en       = (state_r == ST_SCAN) && issue_r;

  // Shared multiplier: operands chosen by the sequencer step.
  always_comb begin
    unique case (state_r)
      ST_MUL0: begin
        mul_a = amount_r;
        mul_b = US_PER_SEC;
      end
      ST_MUL1: begin
        mul_a = quota_r;
        mul_b = 32'(dt_r[SLICE_W-1:0]);
      end
      ST_MUL2: begin
        mul_a = quota_r;
        mul_b = 32'(dt_r[LHS_W-1:SLICE_W]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    issue_nxt     = issue_r;
    cmp_on_nxt    = 1'b0;
    ptr_nxt       = ptr_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r && out_stall;
    quota_nxt     = cfg_wr ? cfg_pwdata : quota_r;
    op_nxt        = op_r;
    hash_nxt      = hash_r;
    now_nxt       = now_r;
    amount_nxt    = amount_r;
    addr_nxt      = addr_r;
    cmp_idx_nxt   = addr_r;
    cmp_live_nxt  = vld_r[addr_r];
    slot_nxt      = slot_r;
    hit_nxt       = hit_r;
    stamp_nxt     = stamp_r;
    over_nxt      = over_r;
    dt_nxt        = dt_r;
    prod_nxt      = prod_r;
    lhs_nxt       = lhs_r;
    acc_nxt       = acc_r;
    sum_nxt       = sum_r;
    out_hit_nxt   = out_hit_r;
    out_stamp_nxt = out_stamp_r;
    out_over_nxt  = out_over_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_opcode;
          hash_nxt   = in_key_hash;
          now_nxt    = in_now_us;
          amount_nxt = in_amount;
          addr_nxt   = '0;
          issue_nxt  = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Reads run one slot ahead of the compare; lowest match wins.
        cmp_on_nxt = issue_r;
        if (issue_r) begin
          if (addr_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end
        if (cmp_on_r) begin
          if (cmp_key == hash_r) begin
            hit_nxt    = 1'b1;
            slot_nxt   = cmp_idx_r;
            stamp_nxt  = cmp_time;
            cmp_on_nxt = 1'b0;
            state_nxt  = ST_ACT;
          end else if (cmp_idx_r == LAST_IDX) begin
            hit_nxt    = 1'b0;
            stamp_nxt  = '0;
            cmp_on_nxt = 1'b0;
            state_nxt  = ST_ACT;
          end
        end
      end
      ST_ACT: begin
        over_nxt = 1'b0;
        if (op_r == OPC_TOUCH) begin
          // A miss claims the next slot in round-robin order.
          if (!hit_r) begin
            ptr_nxt = ptr_inc;
          end
          vld_nxt[ram_wr_addr] = 1'b1;
          stamp_nxt = now_r;
          state_nxt = ST_DONE;
        end else if (!hit_r) begin
          state_nxt = ST_DONE;
        end else begin
          dt_nxt    = now_r - stamp_r;
          state_nxt = ST_MUL0;
        end
      end
      ST_MUL0: begin
        // No elapsed time always counts as overflow.
        if (dt_r == '0) begin
          over_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          prod_nxt  = mul_p;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        lhs_nxt   = prod_r[LHS_W-1:0];
        prod_nxt  = mul_p;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        acc_nxt   = prod_r[PART_W-1:0];
        prod_nxt  = mul_p;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        sum_nxt   = {prod_r[PART_W-1:0], {SLICE_W{1'b0}}} + SUM_W'(acc_r);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // With a nonzero quota, a time step past 2^52 can never overflow.
        if (dt_large) begin
          over_nxt = (quota_r == '0) && (lhs_r != '0);
        end else begin
          over_nxt = SUM_W'(lhs_r) > sum_r;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          out_stamp_nxt = stamp_r;
          out_over_nxt  = over_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_r     <= 1'b0;
      cmp_on_r    <= 1'b0;
      ptr_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      quota_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      cmp_on_r    <= cmp_on_nxt;
      ptr_r       <= ptr_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      quota_r     <= quota_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    hash_r      <= hash_nxt;
    now_r       <= now_nxt;
    amount_r    <= amount_nxt;
    addr_r      <= addr_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    cmp_live_r  <= cmp_live_nxt;
    slot_r      <= slot_nxt;
    hit_r       <= hit_nxt;
    stamp_r     <= stamp_nxt;
    over_r      <= over_nxt;
    dt_r        <= dt_nxt;
    prod_r      <= prod_nxt;
    lhs_r       <= lhs_nxt;
    acc_r       <= acc_nxt;
    sum_r       <= sum_nxt;
    out_hit_r   <= out_hit_nxt;
    out_stamp_r <= out_stamp_nxt;
    out_over_r  <= out_over_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_stamp      = out_stamp_r;
  assign out_over_quota = out_over_r;

endmodule

>>> hw/rtl/pkrl_chk.sv
`include "per_key_rate_limit_table_core_defines.svh"

module pkrl_chk import pkrl_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_hit,
  input logic [TIME_W-1:0] out_stamp,
  input logic              out_over_quota
);

  // A stalled result beat stays and does not change.
  `PKRL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_stamp) && $stable(out_hit) && $stable(out_over_quota), "stalled result beat changed")

  // Only one beat is in work at a time.
  `PKRL_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "input taken while busy")

  // No result can come out right after an input beat is taken.
  `PKRL_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid), "result too early")

  // Overflow is only reported for a key that was found.
  `PKRL_ASSERT_SAME(a_over_needs_hit, out_valid && out_over_quota, out_hit, "overflow on a miss")

endmodule

bind per_key_rate_limit_table_core pkrl_chk u_pkrl_chk (.*);

>>> tb/per_key_rate_limit_table_core_tb.sv
`timescale 1ns / 1ps

module per_key_rate_limit_table_core_tb;
  import pkrl_pkg::*;

  localparam int ENTRIES = 16;
  // A check scans up to every slot and then runs the multiply steps.
  localparam int LAT_CYCLES = ENTRIES + 14;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BEATS = 232;
  localparam int KEY_POOL = 24;
  localparam int unsigned CYCLE_LIMIT = 800000;

  localparam logic [CFG_AW-1:0] QUOTA_ADDR = {REG_QUOTA, 2'b00};
  localparam logic [CFG_AW-1:0] SPARE_ADDR = 3'd4;

  localparam logic [KEY_W-1:0]  KEY_ONES  = '1;
  localparam logic [KEY_W-1:0]  KEY_STRAY = 64'h0123_4567_89AB_CDEF;
  localparam logic [KEY_W-1:0]  KEY_HIGH  = 64'h8000_0000_0000_0001;
  localparam logic [TIME_W-1:0] TIME_MAX  = '1;
  localparam logic [TIME_W-1:0] TIME_MID  = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic                opcode;
    logic [KEY_W-1:0]    key;
    logic [TIME_W-1:0]   now;
    logic [AMOUNT_W-1:0] amount;
  } beat_t;

  typedef struct packed {
    logic              hit;
    logic [TIME_W-1:0] stamp;
    logic              over;
  } verdict_t;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    beat_t             beat;
    bit                known;
    verdict_t          want;
    logic [CFG_AW-1:0] addr;
    logic [CFG_DW-1:0] data;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_opcode;
  logic [KEY_W-1:0]    in_key_hash;
  logic [TIME_W-1:0]   in_now_us;
  logic [AMOUNT_W-1:0] in_amount;
  logic                out_valid;
  logic                out_stall;
  logic                out_hit;
  logic [TIME_W-1:0]   out_stamp;
  logic                out_over_quota;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  // Shadow of the table, the insert pointer and the quota register.
  logic [KEY_W-1:0]   key_slot [ENTRIES];
  logic [TIME_W-1:0]  stamp_slot [ENTRIES];
  int                 insert_ptr;
  logic [QUOTA_W-1:0] quota_shadow;

  verdict_t           awaited_results [$];
  logic [KEY_W-1:0]   key_pool [KEY_POOL];
  logic [TIME_W-1:0]  clock_now;
  int                 errors = 0;
  int                 stall_pct = 0;
  bit                 hold_req = 1'b0;
  int                 hold_left = 0;
  int unsigned        cycle_count = 0;

  per_key_rate_limit_table_core #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_key_hash   (in_key_hash),
    .in_now_us     (in_now_us),
    .in_amount     (in_amount),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_stamp     (out_stamp),
    .out_over_quota(out_over_quota),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  always #6 clk = ~clk;

  // Lowest slot holding the key, or -1 when it is absent.
  function automatic int find_slot_of(input logic [KEY_W-1:0] key);
    for (int k = 0; k < ENTRIES; k++) begin
      if (key_slot[k] == key) return k;
    end
    return -1;
  endfunction

  // Applies one accepted beat to the shadow table and returns its result.
  function automatic verdict_t table_lookup_result(input beat_t b);
    verdict_t          v;
    int                idx;
    logic [TIME_W-1:0] dt;
    logic [63:0]       demand;
    logic [95:0]       allowance;
    idx = find_slot_of(b.key);
    v = '0;
    if (b.opcode == OPC_TOUCH) begin
      v.hit = (idx >= 0);
      // A miss claims the slot after the pointer, whatever it held.
      if (idx < 0) begin
        insert_ptr = (insert_ptr + 1) % ENTRIES;
        idx = insert_ptr;
        key_slot[idx] = b.key;
      end
      stamp_slot[idx] = b.now;
      v.stamp = b.now;
    end else if (idx >= 0) begin
      v.hit = 1'b1;
      v.stamp = stamp_slot[idx];
      dt = b.now - stamp_slot[idx];
      // Exact cross-multiply; zero elapsed time always counts as over.
      demand = 64'(b.amount) * 64'(US_PER_SEC);
      allowance = 96'(quota_shadow) * 96'(dt);
      v.over = (dt == '0) || (96'(demand) > allowance);
    end
    return v;
  endfunction

  function automatic dir_row_t beat_row(input logic op, input logic [KEY_W-1:0] key,
                                        input logic [TIME_W-1:0] now,
                                        input logic [AMOUNT_W-1:0] amt);
    dir_row_t r;
    r.kind = ROW_BEAT;
    r.beat = '{op, key, now, amt};
    r.known = 1'b0;
    r.want = '0;
    r.addr = '0;
    r.data = '0;
    return r;
  endfunction

  function automatic dir_row_t known_row(input logic op, input logic [KEY_W-1:0] key,
                                         input logic [TIME_W-1:0] now,
                                         input logic [AMOUNT_W-1:0] amt, input logic hit,
                                         input logic [TIME_W-1:0] stamp, input logic over);
    dir_row_t r;
    r = beat_row(op, key, now, amt);
    r.known = 1'b1;
    r.want = '{hit, stamp, over};
    return r;
  endfunction

  function automatic dir_row_t reg_row(input logic [CFG_AW-1:0] addr,
                                       input logic [CFG_DW-1:0] data);
    dir_row_t r;
    r = beat_row(OPC_TOUCH, '0, '0, '0);
    r.kind = ROW_REG;
    r.addr = addr;
    r.data = data;
    return r;
  endfunction

  // Random beat: mostly keys from a small pool so touches and checks meet,
  // with times near the stored stamp and near the quota boundary.
  function automatic beat_t random_beat();
    beat_t       b;
    int          idx;
    int          pick;
    logic [63:0] demand;
    logic [63:0] bound;
    b.opcode = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 75) b.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    else if (pick < 96) b.key = {$urandom, $urandom};
    else b.key = '0;
    pick = $urandom_range(0, 99);
    if (pick < 40) b.amount = $urandom_range(0, 1000);
    else if (pick < 65) b.amount = $urandom_range(0, 200000);
    else if (pick < 88) b.amount = $urandom;
    else b.amount = '0;
    idx = find_slot_of(b.key);
    pick = $urandom_range(0, 99);
    if (idx >= 0 && pick < 12) begin
      b.now = stamp_slot[idx];
    end else if (idx >= 0 && pick < 30 && quota_shadow != '0) begin
      demand = 64'(b.amount) * 64'(US_PER_SEC);
      bound = (demand + 64'(quota_shadow) - 64'd1) / 64'(quota_shadow);
      b.now = stamp_slot[idx] + bound + 64'($urandom_range(0, 2)) - 64'd1;
    end else if (pick < 40) begin
      b.now = {$urandom, $urandom};
    end else begin
      clock_now += 64'($urandom_range(0, 3000000));
      b.now = clock_now;
    end
    return b;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    errors++;
  endtask

  // Offers one beat after a random gap and records its result once accepted.
  task automatic send_beat(input beat_t b, input bit known, input verdict_t want,
                           input int idle_pct);
    verdict_t v;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= b.opcode;
    in_key_hash <= b.key;
    in_now_us <= b.now;
    in_amount <= b.amount;
    do @(posedge clk); while (in_stall);
    v = table_lookup_result(b);
    awaited_results.push_back(known ? want : v);
  endtask

  // Drops valid and waits until every result is back and the block is quiet.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
  endtask

  // Register write followed by a read back of the quota register.
  task automatic set_register(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr[CFG_AW-1:2] == REG_QUOTA) quota_shadow = data[QUOTA_W-1:0];
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= QUOTA_ADDR;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DW'(quota_shadow)) begin
      flag_mismatch("quota read back", 64'(cfg_prdata), 64'(quota_shadow));
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Result checker: each accepted beat against the oldest expectation.
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("result with nothing awaited", out_stamp, '0);
      end else begin
        want = awaited_results.pop_front();
        if (out_hit !== want.hit) flag_mismatch("hit", 64'(out_hit), 64'(want.hit));
        if (out_stamp !== want.stamp) flag_mismatch("stamp", out_stamp, want.stamp);
        if (out_over_quota !== want.over) begin
          flag_mismatch("over_quota", 64'(out_over_quota), 64'(want.over));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t          dir_rows [$];
    logic [QUOTA_W-1:0] phase_quota [4];
    int                phase_idle [4];
    int                phase_stall [4];

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OPC_TOUCH;
    in_key_hash = '0;
    in_now_us = '0;
    in_amount = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;

    for (int k = 0; k < ENTRIES; k++) begin
      key_slot[k] = '0;
      stamp_slot[k] = '0;
    end
    insert_ptr = 0;
    quota_shadow = '0;
    foreach (key_pool[k]) key_pool[k] = {$urandom, $urandom};
    clock_now = 64'd1_000_000_000;

    // Directed beats: empty table, hash zero, extremes, exact quota boundary.
    dir_rows.push_back(known_row(OPC_CHECK, KEY_STRAY, 64'd50, 32'd7, 1'b0, '0, 1'b0));
    dir_rows.push_back(known_row(OPC_CHECK, '0, '0, '0, 1'b1, '0, 1'b1));
    dir_rows.push_back(known_row(OPC_TOUCH, '0, 64'd5, '1, 1'b1, 64'd5, 1'b0));
    dir_rows.push_back(known_row(OPC_TOUCH, KEY_ONES, TIME_MAX, '0, 1'b0, TIME_MAX, 1'b0));
    dir_rows.push_back(known_row(OPC_TOUCH, KEY_ONES, 64'd100, '0, 1'b1, 64'd100, 1'b0));
    dir_rows.push_back(known_row(OPC_CHECK, KEY_ONES, 64'd100, '0, 1'b1, 64'd100, 1'b1));
    dir_rows.push_back(known_row(OPC_CHECK, KEY_ONES, 64'd101, '0, 1'b1, 64'd100, 1'b0));
    dir_rows.push_back(known_row(OPC_CHECK, KEY_ONES, 64'd101, 32'd1, 1'b1, 64'd100, 1'b1));
    dir_rows.push_back(known_row(OPC_CHECK, KEY_ONES, 64'd99, '1, 1'b1, 64'd100, 1'b1));
    dir_rows.push_back(known_row(OPC_CHECK, '0, 64'd4, 32'd1, 1'b1, 64'd5, 1'b1));
    dir_rows.push_back(reg_row(QUOTA_ADDR, '1));
    dir_rows.push_back(reg_row(SPARE_ADDR, '0));
    dir_rows.push_back(known_row(OPC_CHECK, KEY_ONES, 64'd1_000_100, '1,
                                 1'b1, 64'd100, 1'b0));
    dir_rows.push_back(known_row(OPC_CHECK, KEY_ONES, 64'd1_000_099, '1,
                                 1'b1, 64'd100, 1'b1));
    dir_rows.push_back(beat_row(OPC_CHECK, KEY_ONES, TIME_MAX, '1));
    dir_rows.push_back(reg_row(QUOTA_ADDR, 32'd1));
    dir_rows.push_back(known_row(OPC_CHECK, KEY_ONES, 64'd1_000_100, 32'd1,
                                 1'b1, 64'd100, 1'b0));
    dir_rows.push_back(known_row(OPC_CHECK, KEY_ONES, 64'd1_000_099, 32'd1,
                                 1'b1, 64'd100, 1'b1));
    dir_rows.push_back(beat_row(OPC_TOUCH, KEY_HIGH, 64'd200, '0));
    dir_rows.push_back(beat_row(OPC_TOUCH, 64'd1, TIME_MID, 32'hAAAA_AAAA));
    dir_rows.push_back(beat_row(OPC_CHECK, 64'd1, TIME_MID + 64'd3, 32'h8000_0000));
    dir_rows.push_back(beat_row(OPC_TOUCH, KEY_ONES, 64'd300, 32'h5555_5555));
    dir_rows.push_back(beat_row(OPC_CHECK, KEY_HIGH, 64'd201, 32'd1));

    // Random phases: quota and idling pattern change between them.
    phase_quota[0] = $urandom_range(1, 5000);
    phase_quota[1] = '0;
    phase_quota[2] = '1;
    phase_quota[3] = $urandom;
    phase_idle[0] = 0;
    phase_idle[1] = 84;
    phase_idle[2] = 0;
    phase_idle[3] = 25;
    phase_stall[0] = 0;
    phase_stall[1] = 0;
    phase_stall[2] = 84;
    phase_stall[3] = 25;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    stall_pct = 20;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        drain_results();
        set_register(dir_rows[i].addr, dir_rows[i].data);
      end else begin
        send_beat(dir_rows[i].beat, dir_rows[i].known, dir_rows[i].want, 20);
      end
    end
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      set_register(QUOTA_ADDR, CFG_DW'(phase_quota[ph]));
      @(posedge clk);
      stall_pct = phase_stall[ph];
      // The first phase opens with a long hold-off while beats keep coming.
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_beat(random_beat(), 1'b0, '0, phase_idle[ph]);
      end
      drain_results();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
